@@ rtl/single_source_shortest_path_assert.svh @@
// Assertion shorthands for the shortest-path block.
// Each check samples on the rising edge of clock and is held off while reset is high.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_ASSERT_SVH

// Same-cycle implication.
`define SSSP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the following cycle.
`define SSSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sssp_pkg.sv @@
`timescale 1ns / 1ps
package sssp_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // Answer kinds on the response channel
   localparam logic ANS_STATUS   = 1'b0;
   localparam logic ANS_DISTANCE = 1'b1;

   // Configuration register indexes
   localparam logic CSR_NODE_COUNT  = 1'b0;
   localparam logic CSR_SOURCE_NODE = 1'b1;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_DATA_W = 9;

   localparam logic [31:0] UNREACHED_DIST = 32'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOOKUP,
      ST_RELAX,
      ST_RUN_DONE,
      ST_READ_WAIT,
      ST_READ_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic load_edge;
      logic clear_edges;
      logic run_start;
      logic ptr_step;
      logic pass_step;
      logic relax_apply;
      logic read_sel;
      logic rsp_run;
      logic rsp_read;
      logic neg_flag;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic src_ok;
      logic no_edges;
      logic ptr_last;
      logic in_check;
      logic improve;
      logic rsp_free;
   } status_type;

endpackage

@@ rtl/sssp_ram.sv @@
`timescale 1ns / 1ps
module sssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sssp_ctrl.sv @@
`timescale 1ns / 1ps
module sssp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sssp_pkg::kind_type    req_kind,
   input  sssp_pkg::status_type  status,
   output sssp_pkg::cmd_type     cmd
);

   sssp_pkg::state_type state_ff, state_in;
   logic                neg_ff, neg_in;
   logic                changed_ff, changed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sssp_pkg::ST_IDLE;
         neg_ff     <= 1'b0;
         changed_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         neg_ff     <= neg_in;
         changed_ff <= changed_in;
      end
   end

   // Next state
   always_comb begin
      state_in   = state_ff;
      neg_in     = neg_ff;
      changed_in = changed_ff;
      unique case (state_ff)
         sssp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_kind)
                  sssp_pkg::KIND_RUN: begin
                     neg_in     = 1'b0;
                     changed_in = 1'b0;
                     if (!status.src_ok || status.no_edges) begin
                        state_in = sssp_pkg::ST_RUN_DONE;
                     end else begin
                        state_in = sssp_pkg::ST_FETCH;
                     end
                  end
                  sssp_pkg::KIND_READ: state_in = sssp_pkg::ST_READ_WAIT;
                  sssp_pkg::KIND_LOAD,
                  sssp_pkg::KIND_CLEAR: state_in = sssp_pkg::ST_IDLE;
                  default: state_in = sssp_pkg::ST_IDLE;
               endcase
            end
         end
         sssp_pkg::ST_FETCH:  state_in = sssp_pkg::ST_LOOKUP;
         sssp_pkg::ST_LOOKUP: state_in = sssp_pkg::ST_RELAX;
         sssp_pkg::ST_RELAX: begin
            if (status.in_check) begin
               // extra pass: any edge that still lowers a distance marks a cycle
               if (status.improve) begin
                  neg_in   = 1'b1;
                  state_in = sssp_pkg::ST_RUN_DONE;
               end else if (status.ptr_last) begin
                  state_in = sssp_pkg::ST_RUN_DONE;
               end else begin
                  state_in = sssp_pkg::ST_FETCH;
               end
            end else begin
               changed_in = changed_ff | status.improve;
               if (status.ptr_last) begin
                  if (!(changed_ff | status.improve)) begin
                     state_in = sssp_pkg::ST_RUN_DONE;
                  end else begin
                     changed_in = 1'b0;
                     state_in   = sssp_pkg::ST_FETCH;
                  end
               end else begin
                  state_in = sssp_pkg::ST_FETCH;
               end
            end
         end
         sssp_pkg::ST_RUN_DONE: begin
            if (status.rsp_free) begin
               state_in = sssp_pkg::ST_IDLE;
            end
         end
         sssp_pkg::ST_READ_WAIT: state_in = sssp_pkg::ST_READ_DONE;
         sssp_pkg::ST_READ_DONE: begin
            if (status.rsp_free) begin
               state_in = sssp_pkg::ST_IDLE;
            end
         end
         default: state_in = sssp_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         sssp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               unique case (req_kind)
                  sssp_pkg::KIND_LOAD:  cmd.load_edge   = 1'b1;
                  sssp_pkg::KIND_CLEAR: cmd.clear_edges = 1'b1;
                  sssp_pkg::KIND_RUN:   cmd.run_start   = 1'b1;
                  sssp_pkg::KIND_READ:  cmd.take        = 1'b1;
                  default:              cmd.take        = 1'b1;
               endcase
            end
         end
         sssp_pkg::ST_FETCH,
         sssp_pkg::ST_LOOKUP: cmd = '0;
         sssp_pkg::ST_RELAX: begin
            cmd.relax_apply = !status.in_check;
            if (!status.ptr_last) begin
               cmd.ptr_step = !(status.in_check && status.improve);
            end else if (!status.in_check) begin
               cmd.pass_step = changed_ff | status.improve;
            end
         end
         sssp_pkg::ST_RUN_DONE: begin
            cmd.rsp_run  = status.rsp_free;
            cmd.neg_flag = neg_ff;
         end
         sssp_pkg::ST_READ_WAIT: cmd.read_sel = 1'b1;
         sssp_pkg::ST_READ_DONE: begin
            cmd.read_sel = 1'b1;
            cmd.rsp_read = status.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/sssp_dpath.sv @@
`timescale 1ns / 1ps
module sssp_dpath #(
   parameter int MAX_NODES   = 256,
   parameter int MAX_EDGES   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sssp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_index,
   input  logic [sssp_pkg::CSR_DATA_W-1:0]   csr_data,
   input  sssp_pkg::cmd_type                 cmd,
   output sssp_pkg::status_type              status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sssp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int NODE_AW  = $clog2(MAX_NODES);
   localparam int NCNT_W   = $clog2(MAX_NODES + 1);
   localparam int EDGE_AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ETOT_W   = $clog2(MAX_EDGES + 1);
   localparam int EDGE_W   = 16 + WEIGHT_BITS;
   localparam int DIST_RAW = WEIGHT_BITS + $clog2(MAX_NODES) + $clog2(MAX_EDGES + 1) + 1;
   localparam int DIST_W   = (DIST_RAW > 33) ? DIST_RAW : 33;

   localparam logic signed [DIST_W-1:0] D_MAX = DIST_W'(64'sh7FFF_FFFF);
   localparam logic signed [DIST_W-1:0] D_MIN = DIST_W'(-64'sh8000_0000);

   // Request fields
   logic [7:0]         req_src, req_dst, req_query;
   logic signed [15:0] req_weight;

   assign req_src    = req_tdata[7:0];
   assign req_dst    = req_tdata[15:8];
   assign req_weight = $signed(req_tdata[31:16]);
   assign req_query  = req_tdata[39:32];

   // Registers
   logic [8:0]           node_count_ff, node_count_in;
   logic [7:0]           source_ff, source_in;
   logic [ETOT_W-1:0]    edge_total_ff, edge_total_in;
   logic                 overflow_ff, overflow_in;
   logic [7:0]           query_ff, query_in;
   logic [NCNT_W-1:0]    n_ff, n_in;
   logic [NCNT_W-1:0]    pass_ff, pass_in;
   logic [EDGE_AW-1:0]   ptr_ff, ptr_in;
   logic [MAX_NODES-1:0] reached_ff, reached_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic                 rsp_neg_ff, rsp_neg_in;
   logic                 rsp_drop_ff, rsp_drop_in;
   logic [7:0]           rsp_node_ff, rsp_node_in;
   logic [31:0]          rsp_dist_ff, rsp_dist_in;
   logic                 rsp_reached_ff, rsp_reached_in;

   // Combinational
   logic [NCNT_W-1:0]        n_calc;
   logic                     src_ok, table_full;
   logic [EDGE_W-1:0]        edge_wr_data, edge_rd_data;
   logic [7:0]               e_tail, e_head;
   logic signed [WEIGHT_BITS-1:0] e_cost;
   logic signed [WEIGHT_BITS-1:0] load_cost;
   logic [NODE_AW-1:0]       tail_idx, head_idx, src_idx, query_idx;
   logic                     dist_we;
   logic [NODE_AW-1:0]       dist_waddr, dist_raddr_a;
   logic [DIST_W-1:0]        dist_wdata, dist_rd_a, dist_rd_b;
   logic signed [DIST_W-1:0] dist_t, dist_h, cand;
   logic                     edge_in_graph, improve;
   logic                     q_reached, rsp_free;
   logic [31:0]              dist_sat;

   // Active node count: zero acts as one, clamp to the node store
   always_comb begin
      if (node_count_ff == 9'd0) begin
         n_calc = NCNT_W'(1);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         n_calc = NCNT_W'(MAX_NODES);
      end else begin
         n_calc = NCNT_W'(node_count_ff);
      end
   end

   assign src_ok     = 32'(source_ff) < 32'(n_calc);
   assign table_full = edge_total_ff == ETOT_W'(MAX_EDGES);
   assign load_cost  = WEIGHT_BITS'(req_weight);
   assign edge_wr_data = {load_cost, req_dst, req_src};

   sssp_ram #(
      .WIDTH (EDGE_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (cmd.load_edge && !table_full),
      .wr_addr (EDGE_AW'(edge_total_ff)),
      .wr_data (edge_wr_data),
      .rd_addr (ptr_ff),
      .rd_data (edge_rd_data)
   );

   assign e_tail = edge_rd_data[7:0];
   assign e_head = edge_rd_data[15:8];
   assign e_cost = $signed(edge_rd_data[EDGE_W-1:16]);

   assign tail_idx  = NODE_AW'(e_tail);
   assign head_idx  = NODE_AW'(e_head);
   assign src_idx   = NODE_AW'(source_ff);
   assign query_idx = NODE_AW'(query_ff);

   // Two copies of the distance store give tail and head reads in the same cycle
   assign dist_we      = (cmd.run_start && src_ok) || (cmd.relax_apply && improve);
   assign dist_waddr   = cmd.run_start ? src_idx : head_idx;
   assign dist_wdata   = cmd.run_start ? '0 : cand;
   assign dist_raddr_a = cmd.read_sel ? query_idx : tail_idx;

   sssp_ram #(
      .WIDTH (DIST_W),
      .DEPTH (MAX_NODES)
   ) u_dist_ram_a (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr_a),
      .rd_data (dist_rd_a)
   );

   sssp_ram #(
      .WIDTH (DIST_W),
      .DEPTH (MAX_NODES)
   ) u_dist_ram_b (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (head_idx),
      .rd_data (dist_rd_b)
   );

   assign dist_t = $signed(dist_rd_a);
   assign dist_h = $signed(dist_rd_b);
   assign cand   = dist_t + DIST_W'(e_cost);

   assign edge_in_graph = (32'(e_tail) < 32'(n_ff)) && (32'(e_head) < 32'(n_ff))
                          && reached_ff[tail_idx];
   assign improve = edge_in_graph && (!reached_ff[head_idx] || (cand < dist_h));

   // Saturate the wide distance to 32 bits on read
   always_comb begin
      if (dist_t > D_MAX) begin
         dist_sat = 32'h7FFF_FFFF;
      end else if (dist_t < D_MIN) begin
         dist_sat = 32'h8000_0000;
      end else begin
         dist_sat = dist_rd_a[31:0];
      end
   end

   assign q_reached = (32'(query_ff) < MAX_NODES) && reached_ff[query_idx];
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      node_count_in  = node_count_ff;
      source_in      = source_ff;
      edge_total_in  = edge_total_ff;
      overflow_in    = overflow_ff;
      query_in       = query_ff;
      n_in           = n_ff;
      pass_in        = pass_ff;
      ptr_in         = ptr_ff;
      reached_in     = reached_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_neg_in     = rsp_neg_ff;
      rsp_drop_in    = rsp_drop_ff;
      rsp_node_in    = rsp_node_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_reached_in = rsp_reached_ff;

      if (csr_valid) begin
         unique case (csr_index)
            sssp_pkg::CSR_NODE_COUNT:  node_count_in = csr_data[8:0];
            sssp_pkg::CSR_SOURCE_NODE: source_in     = csr_data[7:0];
         endcase
      end

      if (cmd.take) begin
         query_in = req_query;
      end

      if (cmd.load_edge) begin
         if (table_full) begin
            overflow_in = 1'b1;
         end else begin
            edge_total_in = edge_total_ff + ETOT_W'(1);
         end
      end
      if (cmd.clear_edges) begin
         edge_total_in = '0;
         overflow_in   = 1'b0;
      end

      if (cmd.run_start) begin
         n_in       = n_calc;
         pass_in    = '0;
         ptr_in     = '0;
         reached_in = '0;
         if (src_ok) begin
            reached_in[src_idx] = 1'b1;
         end
      end
      if (cmd.ptr_step) begin
         ptr_in = ptr_ff + EDGE_AW'(1);
      end
      if (cmd.pass_step) begin
         ptr_in  = '0;
         pass_in = pass_ff + NCNT_W'(1);
      end
      if (cmd.relax_apply && improve) begin
         reached_in[head_idx] = 1'b1;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_run) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = sssp_pkg::ANS_STATUS;
         rsp_neg_in     = cmd.neg_flag;
         rsp_drop_in    = overflow_ff;
         rsp_node_in    = '0;
         rsp_dist_in    = '0;
         rsp_reached_in = 1'b0;
      end
      if (cmd.rsp_read) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = sssp_pkg::ANS_DISTANCE;
         rsp_neg_in     = 1'b0;
         rsp_drop_in    = 1'b0;
         rsp_node_in    = query_ff;
         rsp_dist_in    = q_reached ? dist_sat : sssp_pkg::UNREACHED_DIST;
         rsp_reached_in = q_reached;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 9'd1;
         source_ff     <= '0;
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         n_ff          <= NCNT_W'(1);
         pass_ff       <= '0;
         ptr_ff        <= '0;
         reached_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         source_ff     <= source_in;
         edge_total_ff <= edge_total_in;
         overflow_ff   <= overflow_in;
         n_ff          <= n_in;
         pass_ff       <= pass_in;
         ptr_ff        <= ptr_in;
         reached_ff    <= reached_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff       <= query_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_neg_ff     <= rsp_neg_in;
      rsp_drop_ff    <= rsp_drop_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_reached_ff <= rsp_reached_in;
   end

   assign status.src_ok   = src_ok;
   assign status.no_edges = edge_total_ff == '0;
   assign status.ptr_last = (ETOT_W'(ptr_ff) + ETOT_W'(1)) == edge_total_ff;
   assign status.in_check = pass_ff == (n_ff - NCNT_W'(1));
   assign status.improve  = improve;
   assign status.rsp_free = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {5'd0, rsp_reached_ff, rsp_dist_ff, rsp_node_ff,
                        rsp_drop_ff, rsp_neg_ff};

endmodule

@@ rtl/single_source_shortest_path.sv @@
`timescale 1ns / 1ps
// Shortest distances from one source node over a loaded table of directed weighted
// edges. A read item passes through a wait state and a done state before its answer
// sits in the output register. A run item makes at most node_count passes over the
// edges (node_count - 1 relaxation passes and one check pass for a negative loop),
// ending early once a pass lowers nothing; each edge goes in turn through fetch,
// distance lookup and relax, since the edge table has a single read port. Unreached
// nodes read as 65536 with reached low; a finished answer waits in the output
// register while the next item is taken.
`include "single_source_shortest_path_assert.svh"
module single_source_shortest_path #(
   parameter int MAX_NODES   = 256,
   parameter int MAX_EDGES   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: edge_source[7:0], edge_target[15:8], edge_weight[31:16],
   //            query_node[39:32]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sssp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: kind[1:0]
   input  logic [1:0]                       req_tuser,
   // rsp_tdata: negative_cycle[0], edges_dropped[1], node_id[9:2],
   //            distance[41:10], reached[42], zero fill[47:43]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sssp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: answer_kind[0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [sssp_pkg::CSR_DATA_W-1:0]  csr_data
);

   sssp_pkg::cmd_type    cmd;
   sssp_pkg::status_type status;

   assign csr_ready = 1'b1;

   sssp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (sssp_pkg::kind_type'(req_tuser)),
      .status     (status),
      .cmd        (cmd)
   );

   sssp_dpath #(
      .MAX_NODES   (MAX_NODES),
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A new answer is written only into a free output register
   `SSSP_ASSERT_IMPLIES(a_rsp_no_overwrite, cmd.rsp_run || cmd.rsp_read, !rsp_tvalid || rsp_tready, "answer overwrote a pending beat")
   // A read keeps the block busy for the cycle after its beat
   `SSSP_ASSERT_NEXT(a_read_busy, req_tvalid && req_tready && req_tuser == sssp_pkg::KIND_READ, !req_tready, "read item did not occupy the block")
   // An unreached node always reports the unreached distance
   `SSSP_ASSERT_IMPLIES(a_unreached_dist, rsp_tvalid && rsp_tuser == sssp_pkg::ANS_DISTANCE && !rsp_tdata[42], rsp_tdata[41:10] == sssp_pkg::UNREACHED_DIST, "unreached node with wrong distance")

endmodule

@@ tb/sssp_answer_checker.sv @@
`timescale 1ns / 1ps
module sssp_answer_checker
   import sssp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    answers_owed,
   output int                    runs_checked,
   output int                    reads_checked,
   output int                    cycles_flagged,
   output int                    drops_flagged
);

   localparam int NODE_SLOTS = 256;
   localparam int EDGE_SLOTS = 1024;

   typedef struct {
      logic        answer_kind;
      logic        negative_cycle;
      logic        edges_dropped;
      logic [7:0]  node_id;
      logic [31:0] distance;
      logic        reached;
   } answer_type;

   answer_type answers_due[$];

   logic [7:0]  tail_of [EDGE_SLOTS];
   logic [7:0]  head_of [EDGE_SLOTS];
   logic [15:0] cost_of [EDGE_SLOTS];
   int          edges_held;
   logic        table_overflow;
   longint      dist_of [NODE_SLOTS];
   logic        reach_of [NODE_SLOTS];
   logic [8:0]  nodes_cfg;
   logic [7:0]  source_cfg;

   // One sweep over the table in load order, updating in place.
   // With apply low, report only whether some distance could still drop.
   function automatic logic relax_edges(input int n, input logic apply);
      longint cand;
      int     t;
      int     h;
      int     e;
      logic   lowered;
      lowered = 1'b0;
      for (e = 0; e < edges_held; e++) begin
         t = tail_of[e];
         h = head_of[e];
         if (t < n && h < n && reach_of[t]) begin
            cand = dist_of[t] + longint'($signed(cost_of[e]));
            if (!reach_of[h] || cand < dist_of[h]) begin
               if (!apply)
                  return 1'b1;
               lowered     = 1'b1;
               dist_of[h]  = cand;
               reach_of[h] = 1'b1;
            end
         end
      end
      return lowered;
   endfunction

   // Returns the negative-cycle flag and leaves the distances in dist_of.
   function automatic logic solve_paths();
      int n;
      int p;
      if (nodes_cfg == 0)
         n = 1;
      else if (nodes_cfg > NODE_SLOTS)
         n = NODE_SLOTS;
      else
         n = int'(nodes_cfg);
      for (p = 0; p < NODE_SLOTS; p++) begin
         dist_of[p]  = longint'(UNREACHED_DIST);
         reach_of[p] = 1'b0;
      end
      if (source_cfg >= n)
         return 1'b0;
      dist_of[source_cfg]  = 0;
      reach_of[source_cfg] = 1'b1;
      for (p = 1; p < n; p++)
         if (!relax_edges(n, 1'b1))
            return 1'b0;
      return relax_edges(n, 1'b0);
   endfunction

   task automatic compare_field(input string name, input longint want_v, input longint got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      answer_type fresh;
      int         q;
      int         i;
      if (reset) begin
         answers_due.delete();
         edges_held     = 0;
         table_overflow = 1'b0;
         nodes_cfg      = 9'd1;
         source_cfg     = 8'd0;
         for (i = 0; i < NODE_SLOTS; i++) begin
            dist_of[i]  = longint'(UNREACHED_DIST);
            reach_of[i] = 1'b0;
         end
         fail_count     = 0;
         runs_checked   = 0;
         reads_checked  = 0;
         cycles_flagged = 0;
         drops_flagged  = 0;
      end else begin
         // Answers first: none can belong to an item taken at this same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("answer beat with nothing outstanding: kind %0d data %h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               compare_field("answer_kind", want.answer_kind, rsp_tuser);
               compare_field("negative_cycle", want.negative_cycle, rsp_tdata[0]);
               compare_field("edges_dropped", want.edges_dropped, rsp_tdata[1]);
               compare_field("node_id", want.node_id, rsp_tdata[9:2]);
               compare_field("distance", $signed(want.distance), $signed(rsp_tdata[41:10]));
               compare_field("reached", want.reached, rsp_tdata[42]);
               compare_field("zero fill", 0, rsp_tdata[47:43]);
               if (want.answer_kind == ANS_STATUS)
                  runs_checked++;
               else
                  reads_checked++;
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NODE_COUNT)
               nodes_cfg = csr_data;
            else
               source_cfg = csr_data[7:0];
         end
         if (req_tvalid && req_tready) begin
            fresh = '{default: '0};
            case (req_tuser)
               KIND_LOAD: begin
                  if (edges_held < EDGE_SLOTS) begin
                     tail_of[edges_held] = req_tdata[7:0];
                     head_of[edges_held] = req_tdata[15:8];
                     cost_of[edges_held] = req_tdata[31:16];
                     edges_held++;
                  end else begin
                     table_overflow = 1'b1;
                  end
               end
               KIND_CLEAR: begin
                  // distances survive a clear
                  edges_held     = 0;
                  table_overflow = 1'b0;
               end
               KIND_RUN: begin
                  fresh.answer_kind    = ANS_STATUS;
                  fresh.negative_cycle = solve_paths();
                  fresh.edges_dropped  = table_overflow;
                  if (fresh.negative_cycle)
                     cycles_flagged++;
                  if (fresh.edges_dropped)
                     drops_flagged++;
                  answers_due.push_back(fresh);
               end
               default: begin
                  q                 = req_tdata[39:32];
                  fresh.answer_kind = ANS_DISTANCE;
                  fresh.node_id     = req_tdata[39:32];
                  if (reach_of[q]) begin
                     fresh.reached = 1'b1;
                     if (dist_of[q] > 64'sd2147483647)
                        fresh.distance = 32'h7FFF_FFFF;
                     else if (dist_of[q] < -64'sd2147483648)
                        fresh.distance = 32'h8000_0000;
                     else
                        fresh.distance = dist_of[q][31:0];
                  end else begin
                     fresh.distance = UNREACHED_DIST;
                  end
                  answers_due.push_back(fresh);
               end
            endcase
         end
      end
      answers_owed = answers_due.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import sssp_pkg::*;

   localparam int ITEM_TARGET = 1350;
   localparam int QUIET_TAIL  = 150;
   localparam int LONG_STALL  = 400;
   localparam int SETTLE      = 8;
   localparam int DRAIN       = 40;
   localparam int EDGE_SLOTS  = 1024;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic                  csr_index  = 1'b0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_ready;

   int   fail_count;
   int   answers_owed;
   int   runs_checked;
   int   reads_checked;
   int   cycles_flagged;
   int   drops_flagged;

   logic quiet      = 1'b0;
   logic stall_ask  = 1'b0;
   logic stall_done = 1'b0;
   int   idle_odds  = 3;
   int   items_sent = 0;

   always #5 clock = ~clock;

   single_source_shortest_path dut (.*);

   sssp_answer_checker check (.*);

   // Leaves the beat on the bus once taken; the caller follows with another
   // item or with drain_answers, which drops valid.
   task automatic send_item(input kind_type k, input logic [7:0] s, input logic [7:0] d,
                            input logic [15:0] w, input logic [7:0] q);
      if (!quiet && $urandom_range(0, 9) < idle_odds) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {q, w, d, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_edge(input logic [7:0] s, input logic [7:0] d, input logic [15:0] w);
      send_item(KIND_LOAD, s, d, w, $urandom);
   endtask

   task automatic run_paths();
      send_item(KIND_RUN, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic read_node(input logic [7:0] q);
      send_item(KIND_READ, $urandom, $urandom, $urandom, q);
   endtask

   task automatic clear_table();
      send_item(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic drain_answers();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (answers_owed != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input logic [8:0] nodes, input logic [7:0] src);
      csr_valid <= 1'b1;
      csr_index <= CSR_NODE_COUNT;
      csr_data  <= nodes;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_SOURCE_NODE;
      csr_data  <= {1'b0, src};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_weight(input int mode);
      case (mode)
         0: return 16'($urandom_range(0, 100));
         1: return 16'(int'($urandom_range(0, 120)) - 20);
         2: return 16'($urandom);
         default: begin
            case ($urandom_range(0, 4))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h8001;
               3: return 16'hFFFF;
               default: return 16'h0000;
            endcase
         end
      endcase
   endfunction

   // One graph: set the registers, load a path-like edge set from the source,
   // run, read some nodes, with the odd stray item thrown in.
   task automatic graph_episode(input int force_nodes);
      int         span;
      int         n_edges;
      int         mode;
      int         tail;
      int         head;
      int         i;
      logic [8:0] nodes_reg;
      logic [7:0] src;
      if (force_nodes >= 0) begin
         nodes_reg = 9'(force_nodes);
      end else begin
         case ($urandom_range(0, 9))
            0: nodes_reg = 9'd0;
            1: nodes_reg = 9'($urandom_range(256, 511));
            2: nodes_reg = 9'($urandom_range(17, 255));
            default: nodes_reg = 9'($urandom_range(1, 12));
         endcase
      end
      span = (nodes_reg == 0) ? 1 : (nodes_reg > 256) ? 256 : int'(nodes_reg);
      if ($urandom_range(0, 7) == 0)
         src = 8'($urandom_range(0, 255));
      else
         src = 8'($urandom_range(0, span - 1));
      n_edges   = (span > 16) ? $urandom_range(1, 8) : $urandom_range(1, 3 * span + 4);
      mode      = $urandom_range(0, 3);
      idle_odds = $urandom_range(0, 4) * 2;

      drain_answers();
      configure(nodes_reg, src);
      if ($urandom_range(0, 7) != 0)
         clear_table();
      if ($urandom_range(0, 5) == 0)
         read_node($urandom);
      head = src;
      for (i = 0; i < n_edges; i++) begin
         tail = $urandom_range(0, 1) ? head : $urandom_range(0, span - 1);
         head = $urandom_range(0, span - 1);
         // stray endpoint, usually outside the graph
         if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1))
               head = $urandom_range(0, 255);
            else
               tail = $urandom_range(0, 255);
         end
         load_edge(tail, head, pick_weight(mode));
      end
      run_paths();
      if ($urandom_range(0, 2) == 0)
         drain_answers();
      repeat ($urandom_range(1, 5)) begin
         if ($urandom_range(0, 3) != 0)
            read_node($urandom_range(0, span - 1));
         else
            read_node($urandom);
      end
      if ($urandom_range(0, 4) == 0) begin
         load_edge($urandom_range(0, span - 1), $urandom_range(0, span - 1), pick_weight(mode));
         run_paths();
         read_node($urandom_range(0, span - 1));
      end
      if ($urandom_range(0, 5) == 0) begin
         clear_table();
         read_node($urandom_range(0, span - 1));
      end
   endtask

   // Fill the edge table past its end, then check the dropped-load flag
   // survives until a clear.
   task automatic overflow_episode();
      int i;
      drain_answers();
      configure(9'd3, 8'd0);
      clear_table();
      for (i = 0; i < EDGE_SLOTS + 6; i++)
         load_edge($urandom_range(0, 3), $urandom_range(0, 3), pick_weight(1));
      run_paths();
      for (i = 0; i < 4; i++)
         read_node(i);
      load_edge($urandom_range(0, 2), $urandom_range(0, 2), pick_weight(0));
      run_paths();
      clear_table();
      run_paths();
      read_node(8'd2);
   endtask

   // Receiver: random stalls, one long hold-off on request, none in the tail.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (stall_ask && !stall_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            stall_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 19) < idle_odds) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      #10_000_000;
      $display("single_source_shortest_path regression: fail");
      $finish;
   end

   initial begin
      logic overflow_done;
      overflow_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: one node, source 0, empty table
      read_node(8'd0);
      run_paths();
      read_node(8'd0);

      drain_answers();
      configure(9'd4, 8'd0);
      load_edge(8'd0, 8'd1, 16'h7FFF);
      load_edge(8'd1, 8'd2, 16'h8000);
      load_edge(8'd2, 8'd3, 16'h0000);
      load_edge(8'd3, 8'd255, 16'd5);
      load_edge(8'd255, 8'd0, 16'hFFFF);
      load_edge(8'd2, 8'd2, 16'h0000);
      run_paths();
      read_node(8'd3);
      read_node(8'd255);
      // closes a negative loop through nodes 1 and 2
      load_edge(8'd2, 8'd1, 16'h0000);
      run_paths();
      read_node(8'd1);
      clear_table();
      read_node(8'd3);
      // reached at exactly the unreached marker distance
      load_edge(8'd0, 8'd1, 16'h7FFF);
      load_edge(8'd1, 8'd2, 16'h7FFF);
      load_edge(8'd2, 8'd3, 16'd2);
      run_paths();
      read_node(8'd3);

      // zero nodes acts as one; source beyond the graph reaches nothing
      drain_answers();
      configure(9'd0, 8'd255);
      run_paths();
      read_node(8'd0);

      // hold the answer side off while reads keep coming
      drain_answers();
      configure(9'd2, 8'd0);
      idle_odds = 0;
      stall_ask <= 1'b1;
      repeat (12) read_node($urandom);

      graph_episode(256);
      graph_episode(511);
      graph_episode(1);

      while (items_sent < ITEM_TARGET) begin
         if (!overflow_done && items_sent > 350) begin
            overflow_episode();
            overflow_done = 1'b1;
         end
         quiet <= (items_sent > ITEM_TARGET - QUIET_TAIL);
         graph_episode(-1);
      end

      drain_answers();
      repeat (DRAIN) @(posedge clock);
      $display("covered %0d items: %0d runs (%0d negative cycles, %0d with dropped loads)",
               items_sent, runs_checked, cycles_flagged, drops_flagged);
      $display("and %0d distance reads across varied node counts and sources",
               reads_checked);
      if (fail_count == 0)
         $display("single_source_shortest_path regression: pass");
      else
         $display("single_source_shortest_path regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sssp_pkg.sv
rtl/sssp_ram.sv
rtl/sssp_ctrl.sv
rtl/sssp_dpath.sv
rtl/single_source_shortest_path.sv
tb/sssp_answer_checker.sv
tb/tb.sv
